### rtl/core/assert_macros.svh
// assertion helpers, empty under synthesis
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error("never");
`else
`define ASSERT_IMPL(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

### rtl/core/sha_pkg.sv
package sha_pkg;
	localparam int BlockBytes = 64;
	localparam int LenPos = 56;
	localparam logic [7:0] PadMark = 8'h80;

	typedef enum logic [2:0] {
		ST_IDLE, ST_LOAD, ST_ROUND, ST_FOLD, ST_PAD, ST_EMIT
	} sha_state_t;

	typedef logic [31:0] word_t;

	function automatic word_t round_k(input logic [5:0] i);
		word_t k [64] = '{
			32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
			32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
			32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
			32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
			32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
			32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
			32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
			32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
			32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
			32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
			32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
		return k[i];
	endfunction

	function automatic word_t init_value(input logic var224, input logic [2:0] i);
		word_t a [8] = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
			32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
		word_t b [8] = '{32'hc1059ed8, 32'h367cd507, 32'h3070dd17, 32'hf70e5939,
			32'hffc00b31, 32'h68581511, 32'h64f98fa7, 32'hbefa4fa4};
		return var224 ? b[i] : a[i];
	endfunction

	function automatic word_t ror(input word_t v, input int s);
		return (v >> s) | (v << (32 - s));
	endfunction
endpackage

### rtl/core/sha_round.sv
module sha_round (
	input  sha_pkg::word_t v_in [8],
	input  sha_pkg::word_t k,
	input  sha_pkg::word_t w,
	output sha_pkg::word_t v_out [8]
);
	import sha_pkg::*;
	word_t t1, t2;
	always_comb begin
		t1 = v_in[7] + (ror(v_in[4], 6) ^ ror(v_in[4], 11) ^ ror(v_in[4], 25))
			+ ((v_in[4] & v_in[5]) ^ (~v_in[4] & v_in[6])) + k + w;
		t2 = (ror(v_in[0], 2) ^ ror(v_in[0], 13) ^ ror(v_in[0], 22))
			+ ((v_in[0] & v_in[1]) ^ (v_in[0] & v_in[2]) ^ (v_in[1] & v_in[2]));
		v_out[0] = t1 + t2;
		v_out[1] = v_in[0];
		v_out[2] = v_in[1];
		v_out[3] = v_in[2];
		v_out[4] = v_in[3] + t1;
		v_out[5] = v_in[4];
		v_out[6] = v_in[5];
		v_out[7] = v_in[6];
	end
endmodule

### rtl/core/sha256_sha224_hash_top.sv
// sha-256 / sha-224 streaming hash engine
// slave channel: s_tdata[7:0] = data_byte, s_tuser = mode (0 byte, 1 finish)
// master channel: m_tdata[31:0] = digest_word, m_tdata[34:32] = word_index,
//   m_tlast = last_word; one item per digest word, 8 for sha-256, 7 for sha-224
// variant register: cfg_we / cfg_wdata, write only when the engine is idle;
//   writing reloads the chaining words to that variant's initial values
// throughput: bytes are taken one per cycle, but the 64th of a block
//   starts the compression, which holds s_tready low: the block moves from the
//   byte memory into the schedule words, then 64 rounds (one round per cycle,
//   one schedule word read per round), then the fold
// finish: padding is written to the byte memory one byte per cycle, then
//   one compression; with 56 or more bytes pending the pad and compression
//   run twice before the first word is offered; then the words go out one
//   per accepted item; a stalled receiver holds m_tvalid and the word
//   until m_tready
// reset: chaining words take the sha-256 initial values, counts clear; the
//   byte memory holds no reset value and is always written before it is read
`include "assert_macros.svh"
module sha256_sha224_hash_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // data_byte
	input  logic        s_tuser,   // mode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // digest_word, word_index, zero fill
	output logic        m_tlast,   // last_word
	input  logic        cfg_we,
	input  logic        cfg_wdata
);
	import sha_pkg::*;

	sha_state_t state_q, state_d;
	logic       var_q;
	word_t      ch_q [8];
	word_t      v_q [8];
	word_t      v_nx [8];
	logic [5:0] fill_q;
	logic [63:0] total_q;
	logic [5:0] cnt_q;        // round / load counter
	logic [5:0] pad_q;        // pad write address
	logic       two_q;        // second compression needed
	logic       fin_q;        // compressing during finish
	logic [2:0] oidx_q;

	// byte memory: 32-bit words with byte writes, one registered word read
	word_t      bmem [BlockBytes / 4];
	logic       bwe;
	logic [5:0] bwa;
	logic [7:0] bwd;
	word_t      brd_q;
	logic [3:0] bra;

	// schedule words, 16 registers kept as a shift line; w[i-2], w[i-7],
	// w[i-15] and w[i-16] are tapped from it to form each new word in a round
	word_t      win_q [16];
	word_t      w_cur;
	word_t      w_new;
	logic       s_ld;         // load word into schedule

	sha_round u_round (.v_in(v_q), .k(round_k(cnt_q)), .w(w_cur), .v_out(v_nx));

	always_ff @(posedge clk) begin
		if (bwe) bmem[bwa[5:2]][8*(3 - bwa[1:0]) +: 8] <= bwd;
		brd_q <= bmem[bra];
	end

	assign w_new = (ror(win_q[14], 17) ^ ror(win_q[14], 19) ^ (win_q[14] >> 10))
		+ win_q[9] + (ror(win_q[1], 7) ^ ror(win_q[1], 18) ^ (win_q[1] >> 3)) + win_q[0];
	assign w_cur = (cnt_q < 6'd16) ? win_q[cnt_q[3:0]] : w_new;

	// length byte for pad address
	logic [63:0] bits;
	logic [7:0]  len_byte;
	assign bits = {total_q[60:0], 3'd0};
	assign len_byte = bits[8*(7 - pad_q[2:0]) +: 8];

	always_comb begin
		state_d = state_q;
		bwe = 1'b0;
		bwa = fill_q;
		bwd = s_tdata;
		bra = 4'd0;
		s_ld = 1'b0;
		s_tready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					if (!s_tuser) begin
						bwe = 1'b1;
						if (fill_q == 6'd63) state_d = ST_LOAD;
					end else begin
						state_d = ST_PAD;
					end
				end
			end
			ST_PAD: begin
				bwe = 1'b1;
				bwa = pad_q;
				if (pad_q == fill_q && !two_q) bwd = PadMark;
				else if (pad_q >= 6'(LenPos) && !(fill_q >= 6'(LenPos) && !two_q))
					bwd = len_byte;
				else if (pad_q < fill_q && !two_q) bwd = 8'd0;
				else bwd = 8'd0;
				if (two_q && pad_q >= 6'(LenPos)) bwd = len_byte;
				if (!two_q && fill_q < 6'(LenPos) && pad_q >= 6'(LenPos)) bwd = len_byte;
				if (!two_q && fill_q >= 6'(LenPos) && pad_q > fill_q) bwd = 8'd0;
				if (!two_q && pad_q < fill_q) bwe = 1'b0;
				if (pad_q == 6'd63) state_d = ST_LOAD;
			end
			ST_LOAD: begin
				bra = cnt_q[3:0];
				s_ld = 1'b1;
				if (cnt_q == 6'd16) state_d = ST_ROUND;
			end
			ST_ROUND: begin
				if (cnt_q == 6'd63) state_d = ST_FOLD;
			end
			ST_FOLD: begin
				if (!fin_q) state_d = ST_IDLE;
				else if (!two_q && fill_q >= 6'(LenPos)) state_d = ST_PAD;
				else state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (m_tready && oidx_q == (var_q ? 3'd6 : 3'd7)) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			var_q <= 1'b0;
			for (int i = 0; i < 8; i++) ch_q[i] <= init_value(1'b0, 3'(i));
			for (int i = 0; i < 8; i++) v_q[i] <= '0;
			fill_q <= '0;
			total_q <= '0;
			cnt_q <= '0;
			pad_q <= '0;
			two_q <= 1'b0;
			fin_q <= 1'b0;
			oidx_q <= '0;
		end else begin
			if (cfg_we) begin
				var_q <= cfg_wdata;
				for (int i = 0; i < 8; i++) ch_q[i] <= init_value(cfg_wdata, 3'(i));
			end
			case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					if (s_tvalid && !s_tuser) begin
						fill_q <= fill_q + 6'd1;
						total_q <= total_q + 64'd1;
						fin_q <= 1'b0;
					end else if (s_tvalid) begin
						fin_q <= 1'b1;
						pad_q <= '0;
						two_q <= 1'b0;
					end
				end
				ST_PAD: begin
					pad_q <= pad_q + 6'd1;
					cnt_q <= '0;
				end
				ST_LOAD: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd16) begin
						cnt_q <= '0;
						for (int i = 0; i < 8; i++) v_q[i] <= ch_q[i];
					end
				end
				ST_ROUND: begin
					cnt_q <= cnt_q + 6'd1;
					for (int i = 0; i < 8; i++) v_q[i] <= v_nx[i];
				end
				ST_FOLD: begin
					for (int i = 0; i < 8; i++) ch_q[i] <= ch_q[i] + v_q[i];
					if (fin_q && !two_q && fill_q >= 6'(LenPos)) begin
						two_q <= 1'b1;
						pad_q <= '0;
					end else if (fin_q) begin
						oidx_q <= '0;
					end
				end
				ST_EMIT: begin
					if (m_tready) begin
						oidx_q <= oidx_q + 3'd1;
						if (oidx_q == (var_q ? 3'd6 : 3'd7)) begin
							for (int i = 0; i < 8; i++) ch_q[i] <= init_value(var_q, 3'(i));
							fill_q <= '0;
							total_q <= '0;
							two_q <= 1'b0;
							fin_q <= 1'b0;
						end
					end
				end
				default: ;
			endcase
		end
	end

	// schedule words: loaded from byte memory, then a 16-deep shift line
	always_ff @(posedge clk) begin
		if (s_ld && cnt_q != 6'd0) win_q[cnt_q[3:0] - 4'd1] <= brd_q;
		if (state_q == ST_ROUND && cnt_q >= 6'd16) begin
			for (int i = 0; i < 15; i++) win_q[i] <= win_q[i + 1];
			win_q[15] <= w_new;
		end
	end

	assign m_tvalid = (state_q == ST_EMIT);
	assign m_tdata = {5'd0, oidx_q, ch_q[oidx_q]};
	assign m_tlast = (oidx_q == (var_q ? 3'd6 : 3'd7));

	`ASSERT_IMPL(a_emit_quiet, clk, arst_n, m_tvalid |-> !s_tready)
	`ASSERT_IMPL(a_fill_zero_emit, clk, arst_n, (m_tvalid && m_tready && m_tlast) |=> fill_q == 6'd0)
	`ASSERT_NEVER(a_round_no_accept, clk, arst_n, (state_q == ST_ROUND) && s_tready)
endmodule
